### rtl/fmam_pkg.sv
package fmam_pkg;

  // Register widths and indexes
  localparam int CfgW = 24;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_FENCE_DB   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MOTION_DB  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WARMUP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HEARTBEAT  = 3'd4;

  localparam logic [CfgW-1:0] FENCE_DB_RST  = 24'd750;
  localparam logic [CfgW-1:0] MOTION_DB_RST = 24'd200;
  localparam logic [CfgW-1:0] WARMUP_RST    = 24'd30000;
  localparam logic [CfgW-1:0] COOLDOWN_RST  = 24'd60000;
  localparam logic [CfgW-1:0] HEARTBEAT_RST = 24'd300000;

  // Item kinds
  localparam logic KIND_BOOT = 1'b0;

  // Event codes
  localparam logic [2:0] EV_BOOT          = 3'd0;
  localparam logic [2:0] EV_FENCE_BREAK   = 3'd1;
  localparam logic [2:0] EV_FENCE_RESTORE = 3'd2;
  localparam logic [2:0] EV_MOTION        = 3'd3;
  localparam logic [2:0] EV_MOTION_FENCE  = 3'd4;
  localparam logic [2:0] EV_HEARTBEAT     = 3'd5;

  localparam int MaxEv = 3;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic        fence_raw_broken;
    logic        motion_raw;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic       fence_broken;
    logic       motion_active;
    logic       last_of_run;
  } out_item_t;

  // Command to one debouncer
  typedef struct packed {
    logic apply;
    logic boot;
    logic level;
  } dbc_cmd_t;

  function automatic out_item_t mk_item(logic [2:0] code, logic fence, logic motion);
    out_item_t it;
    it.event_code    = code;
    it.fence_broken  = fence;
    it.motion_active = motion;
    it.last_of_run   = 1'b0;
    return it;
  endfunction

endpackage

### rtl/fmam_debounce.sv
module fmam_debounce #(
  parameter int TIME_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fmam_pkg::dbc_cmd_t          cmd,
  input  logic [fmam_pkg::CfgW-1:0]   hold,
  input  logic [TIME_BITS-1:0]        now,
  output logic                        stable_q,
  output logic                        stable_d,
  output logic                        flip
);

  localparam int CmpW = (TIME_BITS > fmam_pkg::CfgW) ? TIME_BITS : fmam_pkg::CfgW;

  logic                 raw_r, raw_nxt;
  logic                 stable_r, stable_nxt;
  logic [TIME_BITS-1:0] chg_r, chg_nxt;
  logic [TIME_BITS-1:0] age;

  // Raw level tracking and hold-time check
  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    chg_nxt    = chg_r;
    flip       = 1'b0;
    if (cmd.apply) begin
      if (cmd.boot) begin
        raw_nxt    = cmd.level;
        stable_nxt = cmd.level;
      end else begin
        if (cmd.level != raw_r) begin
          raw_nxt = cmd.level;
          chg_nxt = now;
        end
        if ((stable_r != raw_nxt) && (CmpW'(age) >= CmpW'(hold))) begin
          stable_nxt = raw_nxt;
          flip       = 1'b1;
        end
      end
    end
  end

  // wraps modulo 2^TIME_BITS; zero when the raw level changes on this beat
  assign age      = (cmd.level != raw_r) ? '0 : (now - chg_r);
  assign stable_q = stable_r;
  assign stable_d = stable_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      chg_r    <= '0;
    end else begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      chg_r    <= chg_nxt;
    end
  end

endmodule

### rtl/fmam_core.sv
module fmam_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [fmam_pkg::CfgIdxW-1:0]          cfg_idx,
  input  logic [fmam_pkg::CfgW-1:0]             cfg_wdata,
  input  logic                                  go,
  input  fmam_pkg::in_item_t                    item,
  output fmam_pkg::out_item_t [fmam_pkg::MaxEv-1:0] evs,
  output logic [1:0]                            ev_cnt
);

  localparam int CmpW = (TIME_BITS > fmam_pkg::CfgW) ? TIME_BITS : fmam_pkg::CfgW;
  localparam int NowW = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [fmam_pkg::CfgW-1:0] fence_db_r, motion_db_r, warmup_r, cooldown_r, hb_period_r;

  logic [TIME_BITS-1:0] boot_time_r, boot_time_nxt;
  logic [TIME_BITS-1:0] alert_time_r, alert_time_nxt;
  logic                 alert_seen_r, alert_seen_nxt;
  logic [TIME_BITS-1:0] hb_time_r, hb_time_nxt;

  logic [NowW-1:0]      now_ext;
  logic [TIME_BITS-1:0] now;
  logic                 is_boot;
  logic                 warm_ok, cool_ok, hb_due, alert;
  logic [TIME_BITS-1:0] warm_age, cool_age, hb_age;

  fmam_pkg::dbc_cmd_t fence_cmd, motion_cmd;
  logic f_q, f_d, f_flip;
  logic m_q, m_d, m_flip;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fence_db_r  <= fmam_pkg::FENCE_DB_RST;
      motion_db_r <= fmam_pkg::MOTION_DB_RST;
      warmup_r    <= fmam_pkg::WARMUP_RST;
      cooldown_r  <= fmam_pkg::COOLDOWN_RST;
      hb_period_r <= fmam_pkg::HEARTBEAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fmam_pkg::CFG_FENCE_DB:  fence_db_r  <= cfg_wdata;
        fmam_pkg::CFG_MOTION_DB: motion_db_r <= cfg_wdata;
        fmam_pkg::CFG_WARMUP:    warmup_r    <= cfg_wdata;
        fmam_pkg::CFG_COOLDOWN:  cooldown_r  <= cfg_wdata;
        fmam_pkg::CFG_HEARTBEAT: hb_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Time base at TIME_BITS
  assign now_ext = NowW'(item.now_ms);
  assign now     = now_ext[TIME_BITS-1:0];
  assign is_boot = (item.kind == fmam_pkg::KIND_BOOT);

  assign warm_age = now - boot_time_r;
  assign cool_age = now - alert_time_r;
  assign hb_age   = now - hb_time_r;
  assign warm_ok  = CmpW'(warm_age) >= CmpW'(warmup_r);
  assign cool_ok  = CmpW'(cool_age) >= CmpW'(cooldown_r);
  assign hb_due   = !is_boot && (CmpW'(hb_age) >= CmpW'(hb_period_r));

  // Debouncer commands
  assign fence_cmd.apply  = go;
  assign fence_cmd.boot   = is_boot;
  assign fence_cmd.level  = item.fence_raw_broken;
  assign motion_cmd.apply = go && (is_boot || warm_ok);
  assign motion_cmd.boot  = is_boot;
  assign motion_cmd.level = is_boot ? 1'b0 : item.motion_raw;

  fmam_debounce #(.TIME_BITS(TIME_BITS)) u_fence (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (fence_cmd),
    .hold     (fence_db_r),
    .now      (now),
    .stable_q (f_q),
    .stable_d (f_d),
    .flip     (f_flip)
  );

  fmam_debounce #(.TIME_BITS(TIME_BITS)) u_motion (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (motion_cmd),
    .hold     (motion_db_r),
    .now      (now),
    .stable_q (m_q),
    .stable_d (m_d),
    .flip     (m_flip)
  );

  assign alert = !is_boot && m_flip && m_d && (!alert_seen_r || cool_ok);

  // Event list, in order of occurrence
  always_comb begin
    evs    = '0;
    ev_cnt = 2'd0;
    if (is_boot) begin
      evs[0] = fmam_pkg::mk_item(fmam_pkg::EV_BOOT, f_d, m_d);
      ev_cnt = 2'd1;
    end else begin
      if (f_flip) begin
        evs[ev_cnt] = fmam_pkg::mk_item(
          f_d ? fmam_pkg::EV_FENCE_BREAK : fmam_pkg::EV_FENCE_RESTORE, f_d, m_q);
        ev_cnt = ev_cnt + 2'd1;
      end
      if (alert) begin
        evs[ev_cnt] = fmam_pkg::mk_item(
          f_d ? fmam_pkg::EV_MOTION_FENCE : fmam_pkg::EV_MOTION, f_d, m_d);
        ev_cnt = ev_cnt + 2'd1;
      end
      if (hb_due) begin
        evs[ev_cnt] = fmam_pkg::mk_item(fmam_pkg::EV_HEARTBEAT, f_d, m_d);
        ev_cnt = ev_cnt + 2'd1;
      end
    end
  end

  // Timestamp state
  always_comb begin
    boot_time_nxt  = boot_time_r;
    alert_time_nxt = alert_time_r;
    alert_seen_nxt = alert_seen_r;
    hb_time_nxt    = hb_time_r;
    if (go) begin
      if (is_boot) begin
        boot_time_nxt = now;
        hb_time_nxt   = now;
      end else begin
        if (alert) begin
          alert_time_nxt = now;
          alert_seen_nxt = 1'b1;
        end
        if (hb_due) begin
          hb_time_nxt = now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_time_r  <= '0;
      alert_time_r <= '0;
      alert_seen_r <= 1'b0;
      hb_time_r    <= '0;
    end else begin
      boot_time_r  <= boot_time_nxt;
      alert_time_r <= alert_time_nxt;
      alert_seen_r <= alert_seen_nxt;
      hb_time_r    <= hb_time_nxt;
    end
  end

endmodule

### rtl/fmam_evbuf.sv
module fmam_evbuf (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  fmam_pkg::out_item_t [fmam_pkg::MaxEv-1:0] evs,
  input  logic [1:0]                            ev_cnt,
  output logic                                  free,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output fmam_pkg::out_item_t                   out_data
);

  fmam_pkg::out_item_t [fmam_pkg::MaxEv-1:0] evs_r;
  logic [1:0] rem_r, rem_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       take;
  fmam_pkg::out_item_t cur;

  assign out_valid = (rem_r != 2'd0);
  assign take      = out_valid && !out_stall;
  // buffer can take a new run once its last beat leaves
  assign free      = !out_valid || (take && rem_r == 2'd1);

  // Beat selection
  always_comb begin
    unique case (idx_r)
      2'd1:    cur = evs_r[1];
      2'd2:    cur = evs_r[2];
      default: cur = evs_r[0];
    endcase
    out_data             = cur;
    out_data.last_of_run = (rem_r == 2'd1);
  end

  always_comb begin
    rem_nxt = rem_r;
    idx_nxt = idx_r;
    if (load) begin
      rem_nxt = ev_cnt;
      idx_nxt = 2'd0;
    end else if (take) begin
      rem_nxt = rem_r - 2'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      rem_r <= rem_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evs_r <= evs;
    end
  end

endmodule

### rtl/fence_motion_alarm_monitor.sv
// An accepted input beat passes the input register, then the result buffer,
// before its first result beat. Throughput, while out_stall is low: one input
// beat per cycle when it yields at most one result; an input with n results (up
// to 3) holds the buffer until its last beat leaves, one beat per cycle.
// Reset: synchronous, active low; clears control state, loads register defaults.
module fence_motion_alarm_monitor #(
  parameter int TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fmam_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fmam_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fmam_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [fmam_pkg::CfgW-1:0]         cfg_data
);

  fmam_pkg::in_item_t in_r;
  logic               in_vld_r, in_vld_nxt;
  logic               in_take, go, buf_free;
  fmam_pkg::out_item_t [fmam_pkg::MaxEv-1:0] evs;
  logic [1:0]         ev_cnt;

  assign cfg_ready = 1'b1;

  // Input register
  assign go         = in_vld_r && buf_free;
  assign in_stall   = in_vld_r && !buf_free;
  assign in_take    = in_valid && !in_stall;
  assign in_vld_nxt = in_take || (in_vld_r && !go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  fmam_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .go        (go),
    .item      (in_r),
    .evs       (evs),
    .ev_cnt    (ev_cnt)
  );

  fmam_evbuf u_evbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go),
    .evs       (evs),
    .ev_cnt    (ev_cnt),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
